// ===== hdl/cascaded_interrupt_controller_macros.svh =====
// Assertion macros shared by the cascaded interrupt controller RTL.
`ifndef CASCADED_INTERRUPT_CONTROLLER_MACROS_SVH
`define CASCADED_INTERRUPT_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CIC_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("cascaded_interrupt_controller: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define CIC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cascaded_interrupt_controller: next-cycle check failed");

`endif

// ===== hdl/cic_pkg.sv =====
// Types and constants shared by the cascaded interrupt controller.
`timescale 1ns / 1ps
package cic_pkg;

  typedef enum logic [2:0] {
    CMD_TRIGGER = 3'd0,
    CMD_MASK_WR = 3'd1,
    CMD_MASK_RD = 3'd2,
    CMD_BYTE    = 3'd3,
    CMD_POLL    = 3'd4
  } cmd_e;

  localparam int unsigned NumLines    = 16;
  localparam int unsigned CascadeLine = 2;

  localparam logic [7:0]  EoiByte      = 8'h20;
  localparam logic [7:0]  VecPrimary   = 8'h08;
  localparam logic [7:0]  VecSecondary = 8'h68;
  localparam logic [15:0] MaskReset    = 16'hFFFF;
  localparam logic [15:0] KeepUpper    = 16'hFF00;
  localparam logic [15:0] KeepLower    = 16'h00FF;

  typedef struct packed {
    logic [2:0] command;
    logic       which_chip;
    logic [3:0] irq_line;
    logic [7:0] data_byte;
    logic       interrupts_enabled;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       int_valid;
    logic [7:0] interrupt_vector;
  } rsp_t;

  typedef struct packed {
    logic [NumLines-1:0] line_mask;
    logic [NumLines-1:0] pending_requests;
    logic [NumLines-1:0] in_service;
  } state_t;

endpackage

// ===== hdl/cic_req_if.sv =====
// Request channel of the cascaded interrupt controller.
`timescale 1ns / 1ps
interface cic_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       which_chip;
  logic [3:0] irq_line;
  logic [7:0] data_byte;
  logic       interrupts_enabled;

  modport source (output valid, command, which_chip, irq_line, data_byte,
                  interrupts_enabled, input ready);
  modport sink   (input valid, command, which_chip, irq_line, data_byte,
                  interrupts_enabled, output ready);
endinterface

// ===== hdl/cic_rsp_if.sv =====
// Result channel of the cascaded interrupt controller.
`timescale 1ns / 1ps
interface cic_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       int_valid;
  logic [7:0] interrupt_vector;

  modport source (output valid, read_data, int_valid, interrupt_vector, input ready);
  modport sink   (input valid, read_data, int_valid, interrupt_vector, output ready);
endinterface

// ===== hdl/cascaded_interrupt_controller.sv =====
// Top level of the cascaded interrupt controller: request register, state and result register.
`timescale 1ns / 1ps
`include "cascaded_interrupt_controller_macros.svh"
// Usage
// Two cascaded 8-line interrupt controllers with 16 lines; the secondary hangs on line 2.
// Every request on req_i carries one command: trigger a line, write or read a controller's
// mask byte, send a command byte (0x20 is end of interrupt), or poll for an interrupt.
// Every request produces exactly one result on rsp_o, in request order.
// Both channels use valid/ready; a transfer happens on a clock edge with both high.
// A request is captured in an input register, evaluated against the mask, pending and
// in-service registers, and lands in the result register, which drives rsp_o.
// Throughput is one request per cycle while rsp_o is not stalled; the 16-line priority
// encode and the state update sit in a single stage between the two registers.
// When the receiver stalls, the held result stays put and one more request can still be
// accepted into the input register; further requests wait until the result is taken.
// Reset (rst_ni low, asynchronous) masks every line, clears pending and in-service state
// and empties both registers.
module cascaded_interrupt_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  cic_req_if.sink    req_i,
  cic_rsp_if.source  rsp_o
);

  logic            s1_valid_q, s1_valid_d;
  cic_pkg::req_t   s1_req_q;
  cic_pkg::req_t   in_req;
  logic            rsp_valid_q, rsp_valid_d;
  cic_pkg::rsp_t   rsp_q;
  cic_pkg::rsp_t   eval_rsp;
  cic_pkg::state_t state_q;
  cic_pkg::state_t state_d;
  cic_pkg::state_t eval_state;
  logic            advance;
  logic            fire;
  logic            in_accept;

  // The result register frees up when empty or being taken this cycle.
  assign advance   = !rsp_valid_q || rsp_o.ready;
  assign fire      = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;
  assign in_accept = req_i.valid && req_i.ready;

  assign in_req.command            = req_i.command;
  assign in_req.which_chip         = req_i.which_chip;
  assign in_req.irq_line           = req_i.irq_line;
  assign in_req.data_byte          = req_i.data_byte;
  assign in_req.interrupts_enabled = req_i.interrupts_enabled;

  cic_eval u_eval (
    .req_i   (s1_req_q),
    .state_i (state_q),
    .state_o (eval_state),
    .rsp_o   (eval_rsp)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // State moves only when a request is evaluated.
  assign state_d = fire ? eval_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q          <= 1'b0;
      rsp_valid_q         <= 1'b0;
      state_q.line_mask   <= cic_pkg::MaskReset;
      state_q.pending_requests <= '0;
      state_q.in_service  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
      state_q     <= state_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= in_req;
    end
    if (fire) begin
      rsp_q <= eval_rsp;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.read_data        = rsp_q.read_data;
  assign rsp_o.int_valid        = rsp_q.int_valid;
  assign rsp_o.interrupt_vector = rsp_q.interrupt_vector;

  // A delivered interrupt always carries a nonzero vector, and only then.
  `CIC_ASSERT_IMP(a_vec_matches_valid, rsp_valid_q,
                  rsp_q.int_valid == (rsp_q.interrupt_vector != 8'h00))
  // A delivered interrupt never carries mask read data.
  `CIC_ASSERT_IMP(a_poll_no_read, rsp_valid_q && rsp_q.int_valid, rsp_q.read_data == 8'h00)
  // A request that cannot move on stays in the input register.
  `CIC_ASSERT_NEXT(a_s1_holds, s1_valid_q && !advance, s1_valid_q)
  // Controller state changes only when a request is evaluated.
  `CIC_ASSERT_NEXT(a_state_stable, !fire, $stable(state_q))
  // A delivery always leaves something in service.
  `CIC_ASSERT_NEXT(a_delivery_in_service, fire && eval_rsp.int_valid, state_q.in_service != '0)

endmodule

// ===== hdl/cic_eval.sv =====
// Command decode, state update and lowest-line priority encoder.
`timescale 1ns / 1ps
module cic_eval (
  input  cic_pkg::req_t   req_i,
  input  cic_pkg::state_t state_i,
  output cic_pkg::state_t state_o,
  output cic_pkg::rsp_t   rsp_o
);

  logic [15:0] line_bit;
  logic        trig_blocked;
  logic        found;
  logic [3:0]  low_line;
  logic [15:0] low_bit;

  assign line_bit     = 16'(1) << req_i.irq_line;
  assign trig_blocked = state_i.line_mask[req_i.irq_line] ||
                        (req_i.irq_line[3] && state_i.line_mask[cic_pkg::CascadeLine]);

  // Lowest pending line wins.
  always_comb begin
    found    = 1'b0;
    low_line = '0;
    for (int k = cic_pkg::NumLines - 1; k >= 0; k--) begin
      if (state_i.pending_requests[k]) begin
        found    = 1'b1;
        low_line = 4'(k);
      end
    end
  end

  assign low_bit = 16'(1) << low_line;

  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    unique case (req_i.command)
      cic_pkg::CMD_TRIGGER: begin
        if (!trig_blocked) begin
          state_o.pending_requests = state_i.pending_requests | line_bit;
        end
      end
      cic_pkg::CMD_MASK_WR: begin
        if (req_i.which_chip) begin
          state_o.line_mask = {state_i.line_mask[15:8], req_i.data_byte};
        end else begin
          state_o.line_mask = {req_i.data_byte, state_i.line_mask[7:0]};
        end
      end
      cic_pkg::CMD_MASK_RD: begin
        rsp_o.read_data = req_i.which_chip ? state_i.line_mask[7:0]
                                           : state_i.line_mask[15:8];
      end
      cic_pkg::CMD_BYTE: begin
        if (req_i.data_byte == cic_pkg::EoiByte) begin
          state_o.in_service = state_i.in_service &
                               (req_i.which_chip ? cic_pkg::KeepUpper : cic_pkg::KeepLower);
        end
      end
      cic_pkg::CMD_POLL: begin
        if (req_i.interrupts_enabled && (state_i.in_service == '0) && found) begin
          state_o.pending_requests = state_i.pending_requests & ~low_bit;
          state_o.in_service       = low_bit;
          rsp_o.int_valid          = 1'b1;
          if (low_line[3]) begin
            state_o.in_service[cic_pkg::CascadeLine] = 1'b1;
            rsp_o.interrupt_vector = cic_pkg::VecSecondary + {4'b0, low_line};
          end else begin
            rsp_o.interrupt_vector = cic_pkg::VecPrimary + {4'b0, low_line};
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the cascaded interrupt controller: directed table, then random requests.
`timescale 1ns / 1ps
module testbench;
  import cic_pkg::*;

  // The highest command code, which the block does not use. Requests with this code,
  // and with the other unused codes, must leave all state alone and return zeros.
  localparam logic [2:0] CMD_SPARE = 3'd7;

  // Number of cycles in which neither channel moves before the run is declared hung.
  // The longest correct quiet stretch is the long receiver hold-off plus a sender gap,
  // so this leaves a wide margin.
  localparam int unsigned IdleLimit = 1000;

  // Minimum total number of requests: the directed table plus the random part.
  localparam int unsigned TotalRequests = 1250;

  // One row of stimulus. When typed is set, rsp is the result read straight off the
  // behavior; otherwise the predictor supplies the expected result.
  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t rsp;
  } cic_stim_t;

  logic clk;
  logic rst_n;

  cic_req_if req_if ();
  cic_rsp_if rsp_if ();

  cascaded_interrupt_controller dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Predicted controller state, updated in request order as requests are accepted.
  logic [15:0] sim_mask;
  logic [15:0] sim_pending;
  logic [15:0] sim_in_service;

  cic_stim_t stim_q[$];
  rsp_t      due_rsp_q[$];

  int unsigned requests_done;
  int unsigned results_seen;
  int unsigned error_count;

  // ---------------------------------------------------------------------------
  // Clock: 10 ns period.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Applies one command to the predicted state and returns the result
  // that the controller should give for it.
  // ---------------------------------------------------------------------------
  function automatic rsp_t apply_cic_command(req_t r);
    rsp_t        res;
    logic [15:0] line_bit;
    logic        found;
    res = '0;
    found = 1'b0;
    case (r.command)
      CMD_TRIGGER: begin
        // A masked line is dropped, and so is any secondary line while the cascade
        // input of the primary controller is masked.
        line_bit = 16'(1) << r.irq_line;
        if ((sim_mask & line_bit) == '0 && !(r.irq_line > 4'd7 && sim_mask[CascadeLine])) begin
          sim_pending = sim_pending | line_bit;
        end
      end
      CMD_MASK_WR: begin
        if (r.which_chip) begin
          sim_mask[7:0] = r.data_byte;
        end else begin
          sim_mask[15:8] = r.data_byte;
        end
      end
      CMD_MASK_RD: begin
        res.read_data = r.which_chip ? sim_mask[7:0] : sim_mask[15:8];
      end
      CMD_BYTE: begin
        // Only the end-of-interrupt byte has an effect; it clears the selected
        // controller's half of the in-service register.
        if (r.data_byte == EoiByte) begin
          sim_in_service = sim_in_service & (r.which_chip ? KeepUpper : KeepLower);
        end
      end
      CMD_POLL: begin
        // A poll delivers only when the CPU allows interrupts and nothing is in
        // service; the lowest pending line wins.
        if (r.interrupts_enabled && sim_in_service == '0) begin
          for (int k = 0; k < NumLines; k++) begin
            if (!found && sim_pending[k]) begin
              found = 1'b1;
              sim_pending[k] = 1'b0;
              sim_in_service[k] = 1'b1;
              res.int_valid = 1'b1;
              if (k > 7) begin
                sim_in_service[CascadeLine] = 1'b1;
                res.interrupt_vector = VecSecondary + 8'(k);
              end else begin
                res.interrupt_vector = VecPrimary + 8'(k);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic cic_stim_t stim_row(logic [2:0] cmd, logic chip, logic [3:0] line,
                                         logic [7:0] data, logic ie, logic typed,
                                         logic [7:0] rd, logic iv, logic [7:0] vec);
    cic_stim_t s;
    s.req.command            = cmd;
    s.req.which_chip         = chip;
    s.req.irq_line           = line;
    s.req.data_byte          = data;
    s.req.interrupts_enabled = ie;
    s.typed                  = typed;
    s.rsp.read_data          = rd;
    s.rsp.int_valid          = iv;
    s.rsp.interrupt_vector   = vec;
    return s;
  endfunction

  // A request with the given command and every other field random, so that fields a
  // command does not use still toggle.
  function automatic req_t random_req(logic [2:0] cmd);
    req_t r;
    r.command            = cmd;
    r.which_chip         = 1'($urandom_range(0, 1));
    r.irq_line           = 4'($urandom_range(0, 15));
    r.data_byte          = 8'($urandom_range(0, 255));
    r.interrupts_enabled = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic void push_req(req_t r);
    cic_stim_t s;
    s.req   = r;
    s.typed = 1'b0;
    s.rsp   = '0;
    stim_q.push_back(s);
  endfunction

  // Directed part: reset values, masked and unmasked triggers, priority, the poll that
  // is refused while the CPU blocks interrupts or while a line is in service, the
  // ignored command byte, end of interrupt on each controller, the cascade line
  // holding the secondary in service, a masked cascade line, and an unused code.
  task automatic build_directed_stimulus();
    cic_stim_t tbl[28];
    tbl[0]  = stim_row(CMD_MASK_RD, 1'b1, 4'h0, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0, 8'h00);
    tbl[1]  = stim_row(CMD_MASK_RD, 1'b0, 4'h0, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0, 8'h00);
    tbl[2]  = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[3]  = stim_row(CMD_TRIGGER, 1'b1, 4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[4]  = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[5]  = stim_row(CMD_MASK_WR, 1'b1, 4'h0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[6]  = stim_row(CMD_MASK_WR, 1'b0, 4'hF, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[7]  = stim_row(CMD_MASK_RD, 1'b1, 4'h0, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[8]  = stim_row(CMD_TRIGGER, 1'b0, 4'hF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[9]  = stim_row(CMD_TRIGGER, 1'b1, 4'h0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[10] = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[11] = stim_row(CMD_POLL,    1'b0, 4'hF, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 8'h08);
    tbl[12] = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[13] = stim_row(CMD_BYTE,    1'b1, 4'h0, 8'h21, 1'b0, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[14] = stim_row(CMD_BYTE,    1'b1, 4'h0, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[15] = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 8'h77);
    tbl[16] = stim_row(CMD_BYTE,    1'b0, 4'h0, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[17] = stim_row(CMD_TRIGGER, 1'b1, 4'h3, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[18] = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[19] = stim_row(CMD_BYTE,    1'b1, 4'h0, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[20] = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 8'h0B);
    tbl[21] = stim_row(CMD_MASK_WR, 1'b1, 4'h0, 8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[22] = stim_row(CMD_TRIGGER, 1'b0, 4'h8, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[23] = stim_row(CMD_BYTE,    1'b1, 4'h0, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[24] = stim_row(CMD_POLL,    1'b1, 4'h0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[25] = stim_row(CMD_SPARE,   1'b1, 4'hF, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 8'h00);
    tbl[26] = stim_row(CMD_MASK_WR, 1'b0, 4'h0, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00);
    tbl[27] = stim_row(CMD_MASK_RD, 1'b0, 4'h0, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0, 8'h00);
    foreach (tbl[i]) begin
      stim_q.push_back(tbl[i]);
    end
  endtask

  // Random part. Most of it is interrupt sessions: open some mask bits (keeping the
  // cascade line open most of the time), raise a few lines, poll, then mostly send end
  // of interrupt to both controllers. The rest is short bursts of fully random requests,
  // unused command codes included.
  task automatic build_random_stimulus();
    req_t       r;
    int         n;
    logic [7:0] d;
    while (stim_q.size() < TotalRequests) begin
      if ($urandom_range(0, 9) < 3) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          push_req(random_req(3'($urandom_range(0, CMD_SPARE))));
        end
      end else begin
        if ($urandom_range(0, 9) < 4) begin
          r = random_req(CMD_MASK_WR);
          r.which_chip = 1'b1;
          d = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) != 0) d = d & 8'($urandom_range(0, 255));
          if ($urandom_range(0, 4) != 0) d[CascadeLine] = 1'b0;
          r.data_byte = d;
          push_req(r);
        end
        if ($urandom_range(0, 9) < 4) begin
          r = random_req(CMD_MASK_WR);
          r.which_chip = 1'b0;
          d = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) != 0) d = d & 8'($urandom_range(0, 255));
          r.data_byte = d;
          push_req(r);
        end
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          push_req(random_req(CMD_TRIGGER));
        end
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          r = random_req(CMD_POLL);
          r.interrupts_enabled = ($urandom_range(0, 7) != 0);
          push_req(r);
        end
        if ($urandom_range(0, 4) != 0) begin
          // End of interrupt to both controllers, in either order.
          r = random_req(CMD_BYTE);
          r.data_byte = EoiByte;
          push_req(r);
          r = random_req(CMD_BYTE);
          r.which_chip = !stim_q[$].req.which_chip;
          r.data_byte = EoiByte;
          push_req(r);
        end else begin
          push_req(random_req(CMD_BYTE));
        end
        if ($urandom_range(0, 4) == 0) begin
          push_req(random_req(CMD_MASK_RD));
        end
      end
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Offers the stimulus in bursts of random length separated by
  // random gaps; roughly a quarter of the bursts follow on with no gap at all.
  // A request stays on the bus unchanged until it is accepted. The expected result
  // of each request is computed at the edge where it is accepted.
  // ---------------------------------------------------------------------------
  initial begin : request_driver
    int unsigned next_row;
    int          gap_left;
    int          burst_left;
    logic        next_valid;
    cic_stim_t   s;
    rsp_t        guess;
    req_if.valid              <= 1'b0;
    req_if.command            <= '0;
    req_if.which_chip         <= 1'b0;
    req_if.irq_line           <= '0;
    req_if.data_byte          <= '0;
    req_if.interrupts_enabled <= 1'b0;
    next_row   = 0;
    gap_left   = 0;
    burst_left = $urandom_range(1, 30);
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (requests_done < stim_q.size()) begin
      @(posedge clk);
      if (req_if.valid && req_if.ready) begin
        // Requests are accepted in order, so the accepted one is the oldest
        // not yet counted.
        s = stim_q[requests_done];
        guess = apply_cic_command(s.req);
        due_rsp_q.push_back(s.typed ? s.rsp : guess);
        requests_done++;
      end
      // A request that was offered and not taken is held as it is.
      if (!(req_if.valid && !req_if.ready)) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (next_row < stim_q.size()) begin
          s = stim_q[next_row];
          next_row++;
          next_valid = 1'b1;
          req_if.command            <= s.req.command;
          req_if.which_chip         <= s.req.which_chip;
          req_if.irq_line           <= s.req.irq_line;
          req_if.data_byte          <= s.req.data_byte;
          req_if.interrupts_enabled <= s.req.interrupts_enabled;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        req_if.valid <= next_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. Checks each accepted result against the oldest expectation and
  // then picks its ready for the next cycle. It periodically switches between always
  // ready, a fixed stall pattern, random stalls and slow bursts. Twice in the run it
  // holds ready low while the driver keeps offering, so that the block fills both of
  // its registers and stalls its request channel.
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int unsigned cycle;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned next_hold_at;
    logic        next_ready;
    rsp_t        want;
    rsp_if.ready <= 1'b0;
    cycle        = 0;
    mode         = 0;
    hold_left    = 0;
    next_hold_at = 300;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (due_rsp_q.size() == 0) begin
          report_mismatch("result with no request awaiting it", rsp_if.interrupt_vector, 0);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_if.read_data !== want.read_data) begin
            report_mismatch("read_data", rsp_if.read_data, want.read_data);
          end
          if (rsp_if.int_valid !== want.int_valid) begin
            report_mismatch("int_valid", rsp_if.int_valid, want.int_valid);
          end
          if (rsp_if.interrupt_vector !== want.interrupt_vector) begin
            report_mismatch("interrupt_vector", rsp_if.interrupt_vector,
                            want.interrupt_vector);
          end
        end
      end
      cycle++;
      if (cycle % 50 == 0) mode = $urandom_range(0, 3);
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = 80;
        next_hold_at = next_hold_at + 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (mode)
          0: next_ready = 1'b1;
          1: next_ready = (cycle % 4 != 3);
          2: next_ready = 1'($urandom_range(0, 1));
          default: next_ready = (cycle % 16 < 5);
        endcase
      end
      rsp_if.ready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if neither channel moves for IdleLimit cycles.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: build the stimulus, reset once, wait for every request to be
  // accepted and every result to arrive, let the pipeline run on so that any stray
  // result shows, then give the verdict.
  // ---------------------------------------------------------------------------
  initial begin : run_control
    rst_n          <= 1'b0;
    sim_mask       = MaskReset;
    sim_pending    = '0;
    sim_in_service = '0;
    requests_done  = 0;
    results_seen   = 0;
    error_count    = 0;
    build_directed_stimulus();
    build_random_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (requests_done < stim_q.size()) @(posedge clk);
    while (due_rsp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== cascaded_interrupt_controller.f =====
+incdir+hdl
hdl/cic_pkg.sv
hdl/cic_req_if.sv
hdl/cic_rsp_if.sv
hdl/cic_eval.sv
hdl/cascaded_interrupt_controller.sv
sim/testbench.sv
